FILE: hdl/pkcl_pkg.sv
package pkcl_pkg;

    localparam int FLOW_KEY_W        = 32;
    localparam int LIMIT_W           = 16;
    localparam int COUNT_W           = 16;
    localparam int CODE_W            = 10;
    localparam int STATUS_W          = 3;
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_KEY_BITS      = 32;

    localparam logic [CODE_W-1:0] CODE_ERROR = 10'd500;
    localparam logic [CODE_W-1:0] CODE_RESET = 10'd402;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADMIT     = 3'd0,
        ST_LIMIT     = 3'd1,
        ST_NOKEY     = 3'd2,
        ST_FULL      = 3'd3,
        ST_ENDED     = 3'd4,
        ST_END_NOKEY = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_LOOK = 2'd2,
        S_EXE  = 2'd3
    } t_state;

    typedef struct packed {
        logic load;
        logic compare;
        logic lookup;
        logic exec;
    } t_cmd;

endpackage

FILE: hdl/pkcl_ram.sv
module pkcl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/pkcl_ctrl.sv
module pkcl_ctrl
    import pkcl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP:   n_state = S_LOOK;
            S_LOOK:  n_state = S_EXE;
            S_EXE:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_CMP:   o_cmd.compare = 1'b1;
            S_LOOK:  o_cmd.lookup  = 1'b1;
            S_EXE:   o_cmd.exec    = 1'b1;
            default: o_busy        = 1'b1;
        endcase
    end

endmodule

FILE: hdl/pkcl_dp.sv
module pkcl_dp
    import pkcl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_op,
    input  logic                  i_key_present,
    input  logic [FLOW_KEY_W-1:0] i_flow_key,
    input  logic [LIMIT_W-1:0]    i_max_sessions,
    input  logic                  i_cfg_valid,
    input  logic [CODE_W-1:0]     i_cfg_data,
    output logic                  o_result_valid,
    output t_status               o_status,
    output logic [CODE_W-1:0]     o_reply_code,
    output logic [COUNT_W-1:0]    o_active_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [KEY_BITS-1:0]      w_key;
    logic                     r_op;
    logic                     r_has_key;
    logic [KEY_BITS-1:0]      r_key;
    logic [LIMIT_W-1:0]       r_limit;
    logic [CODE_W-1:0]        r_cfg_code;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [KEY_BITS-1:0]      r_entry_key [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_match;

    logic                     w_hit;
    logic [IDX_W-1:0]         w_hit_idx;
    logic                     w_free_any;
    logic [IDX_W-1:0]         w_free_idx;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hit_idx;
    logic                     r_free_any;
    logic [IDX_W-1:0]         r_free_idx;

    logic [COUNT_W-1:0]       w_rd_count;
    logic                     w_we;
    logic [IDX_W-1:0]         w_waddr;
    logic [COUNT_W-1:0]       w_wdata;
    logic                     w_alloc;
    logic                     w_release;

    t_status                  n_status;
    logic [CODE_W-1:0]        n_code;
    logic [COUNT_W-1:0]       n_count;
    logic                     r_out_valid;
    t_status                  r_out_status;
    logic [CODE_W-1:0]        r_out_code;
    logic [COUNT_W-1:0]       r_out_count;

    // Only the low KEY_BITS bits of the flow key take part in the compare.
    generate
        if (KEY_BITS > FLOW_KEY_W) begin : g_key_wide
            assign w_key = {{(KEY_BITS - FLOW_KEY_W){1'b0}}, i_flow_key};
        end else if (KEY_BITS == FLOW_KEY_W) begin : g_key_same
            assign w_key = i_flow_key;
        end else begin : g_key_narrow
            assign w_key = i_flow_key[KEY_BITS-1:0];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_code <= CODE_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_code <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_has_key <= i_key_present;
            r_key     <= w_key;
            r_limit   <= i_max_sessions;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= '0;
        end else if (i_cmd.compare) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                r_match[i] <= r_valid[i] && (r_entry_key[i] == r_key);
            end
        end
    end

    // Lowest-numbered hit and lowest-numbered free slot.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_free_any = 1'b0;
        w_free_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_free_any = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= w_hit;
            r_hit_idx  <= w_hit_idx;
            r_free_any <= w_free_any;
            r_free_idx <= w_free_idx;
        end
    end

    pkcl_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.lookup),
        .i_raddr (w_hit_idx),
        .o_rdata (w_rd_count)
    );

    always_comb begin
        n_status  = ST_ADMIT;
        n_code    = '0;
        n_count   = '0;
        w_we      = 1'b0;
        w_waddr   = r_hit_idx;
        w_wdata   = '0;
        w_alloc   = 1'b0;
        w_release = 1'b0;
        if (!r_op) begin
            if (!r_has_key) begin
                n_status = ST_NOKEY;
                n_code   = CODE_ERROR;
            end else if (r_limit != '0) begin
                if (r_hit) begin
                    if (w_rd_count < r_limit) begin
                        w_we    = 1'b1;
                        w_wdata = w_rd_count + COUNT_W'(1);
                        n_count = w_wdata;
                    end else begin
                        n_status = ST_LIMIT;
                        n_code   = r_cfg_code;
                        n_count  = w_rd_count;
                    end
                end else if (r_free_any) begin
                    w_alloc = 1'b1;
                    w_we    = 1'b1;
                    w_waddr = r_free_idx;
                    w_wdata = COUNT_W'(1);
                    n_count = COUNT_W'(1);
                end else begin
                    n_status = ST_FULL;
                    n_code   = CODE_ERROR;
                end
            end
        end else begin
            if (!r_has_key) begin
                n_status = ST_END_NOKEY;
            end else begin
                n_status = ST_ENDED;
                if (r_hit) begin
                    if (w_rd_count > COUNT_W'(1)) begin
                        w_we    = 1'b1;
                        w_wdata = w_rd_count - COUNT_W'(1);
                        n_count = w_wdata;
                    end else begin
                        w_release = 1'b1;
                    end
                end
            end
        end
        if (!i_cmd.exec) begin
            w_we      = 1'b0;
            w_alloc   = 1'b0;
            w_release = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_alloc) begin
            r_valid[r_free_idx] <= 1'b1;
        end else if (w_release) begin
            r_valid[r_hit_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_alloc) begin
            r_entry_key[r_free_idx] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_status <= n_status;
            r_out_code   <= n_code;
            r_out_count  <= n_count;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_reply_code   = r_out_code;
    assign o_active_count = r_out_count;

`ifndef SYNTHESIS
    // A key is never stored in two slots.
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_match))
        else $error("flow key matched more than one slot");

    a_result_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(i_cmd.exec))
        else $error("result strobe without a finished item");

    a_limit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_LIMIT) |-> (o_active_count != '0))
        else $error("limit refusal on a slot with zero count");

    a_full_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_FULL) |-> (&r_valid))
        else $error("table full reported while a slot is free");
`endif

endmodule

FILE: hdl/per_key_concurrency_limiter.sv
// Channel   Direction  Handshake                    Payload
// item      in         start high while busy low    i_op, i_key_present, i_flow_key,
//                                                   i_max_sessions
// result    out        o_result_valid, one cycle    o_status, o_reply_code, o_active_count
// config    in         i_cfg_valid and o_cfg_ready  i_cfg_data
//
// Each item goes through accept, key compare across all slots, slot select with the
// count memory read, then the update; the result strobe is registered in the cycle
// after the update, while the next item may already be accepted.
// The registered key compare, slot select and count memory read set this sequence.
// Reset clears all slot valid bits at once and loads the refusal code with 402.
// Results cannot be stalled; config is always ready.
module per_key_concurrency_limiter
    import pkcl_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int KEY_BITS      = DEF_KEY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_op,
    input  logic                  i_key_present,
    input  logic [FLOW_KEY_W-1:0] i_flow_key,
    input  logic [LIMIT_W-1:0]    i_max_sessions,
    output logic                  o_result_valid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CODE_W-1:0]     o_reply_code,
    output logic [COUNT_W-1:0]    o_active_count,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CODE_W-1:0]     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    pkcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    pkcl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BITS      (KEY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_key_present  (i_key_present),
        .i_flow_key     (i_flow_key),
        .i_max_sessions (i_max_sessions),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_status       (w_status),
        .o_reply_code   (o_reply_code),
        .o_active_count (o_active_count)
    );

    assign o_status    = w_status;
    assign o_cfg_ready = 1'b1;

endmodule

FILE: test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pkcl_pkg::*;

    localparam logic OP_START = 1'b0;
    localparam logic OP_END   = 1'b1;

    localparam int SLOTS    = DEF_TABLE_ENTRIES;
    localparam int CMP_BITS = (DEF_KEY_BITS < FLOW_KEY_W) ? DEF_KEY_BITS : FLOW_KEY_W;
    localparam logic [FLOW_KEY_W-1:0] KEY_MASK = {FLOW_KEY_W{1'b1}} >> (FLOW_KEY_W - CMP_BITS);

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 12;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 260;
    localparam int MAX_REPORTS  = 40;

    typedef struct {
        logic                  op;
        logic                  key_present;
        logic [FLOW_KEY_W-1:0] flow_key;
        logic [LIMIT_W-1:0]    max_sessions;
    } t_session_item;

    typedef struct {
        t_status             status;
        logic [CODE_W-1:0]   code;
        logic [COUNT_W-1:0]  count;
    } t_session_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  start          = 1'b0;
    logic                  i_op           = 1'b0;
    logic                  i_key_present  = 1'b0;
    logic [FLOW_KEY_W-1:0] i_flow_key     = '0;
    logic [LIMIT_W-1:0]    i_max_sessions = '0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CODE_W-1:0]     i_cfg_data     = '0;

    logic                  busy;
    logic                  o_result_valid;
    logic [STATUS_W-1:0]   o_status;
    logic [CODE_W-1:0]     o_reply_code;
    logic [COUNT_W-1:0]    o_active_count;
    logic                  o_cfg_ready;

    per_key_concurrency_limiter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_key_present  (i_key_present),
        .i_flow_key     (i_flow_key),
        .i_max_sessions (i_max_sessions),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_reply_code   (o_reply_code),
        .o_active_count (o_active_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow copy of the session table and the refusal code.
    logic                  slot_valid [SLOTS];
    logic [FLOW_KEY_W-1:0] slot_key   [SLOTS];
    logic [COUNT_W-1:0]    slot_count [SLOTS];
    logic [CODE_W-1:0]     shadow_code;

    t_session_item   pending_items[$];
    t_session_result expected_replies[$];

    int  queued_items   = 0;
    int  accepted_items = 0;
    int  cfg_transfers  = 0;
    int  fail_count     = 0;
    int  cycle_count    = 0;
    int  gap_left       = 0;
    bit  item_taken     = 1'b0;
    bit  quiet          = 1'b0;

    function automatic t_session_result predict_session(input t_session_item it);
        t_session_result       r;
        logic [FLOW_KEY_W-1:0] key;
        int                    hit;
        int                    free_idx;
        r.status = ST_ADMIT;
        r.code   = '0;
        r.count  = '0;
        key      = it.flow_key & KEY_MASK;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key && hit < 0)
                hit = i;
            if (!slot_valid[i] && free_idx < 0)
                free_idx = i;
        end
        if (it.op == OP_START) begin
            if (!it.key_present) begin
                r.status = ST_NOKEY;
                r.code   = CODE_ERROR;
            end else if (it.max_sessions != '0) begin
                if (hit < 0) begin
                    if (free_idx < 0) begin
                        r.status = ST_FULL;
                        r.code   = CODE_ERROR;
                    end else begin
                        slot_valid[free_idx] = 1'b1;
                        slot_key[free_idx]   = key;
                        slot_count[free_idx] = COUNT_W'(1);
                        r.count              = COUNT_W'(1);
                    end
                end else begin
                    if (slot_count[hit] < it.max_sessions) begin
                        slot_count[hit] = slot_count[hit] + COUNT_W'(1);
                    end else begin
                        r.status = ST_LIMIT;
                        r.code   = shadow_code;
                    end
                    r.count = slot_count[hit];
                end
            end
        end else begin
            if (!it.key_present) begin
                r.status = ST_END_NOKEY;
            end else begin
                r.status = ST_ENDED;
                if (hit >= 0) begin
                    if (slot_count[hit] > COUNT_W'(1)) begin
                        slot_count[hit] = slot_count[hit] - COUNT_W'(1);
                        r.count         = slot_count[hit];
                    end else begin
                        slot_valid[hit] = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
        end
    endtask

    task automatic queue_item(input logic op, input logic kp,
                              input logic [FLOW_KEY_W-1:0] key,
                              input logic [LIMIT_W-1:0] lim);
        t_session_item it;
        it.op           = op;
        it.key_present  = kp;
        it.flow_key     = key;
        it.max_sessions = lim;
        pending_items.push_back(it);
        queued_items++;
    endtask

    // Driver: holds an item on the ports until its transfer, with random idle bursts.
    always @(negedge i_clk) begin
        t_session_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_items.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(0, 10);
                start <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_op           <= it.op;
                i_key_present  <= it.key_present;
                i_flow_key     <= it.flow_key;
                i_max_sessions <= it.max_sessions;
                start          <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, predicts accepted items and tracks register writes.
    always @(posedge i_clk) begin
        t_session_item   seen;
        t_session_result exp_r;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_replies.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            item_taken = 1'b0;
            if (!i_rst_n) begin
                for (int i = 0; i < SLOTS; i++)
                    slot_valid[i] = 1'b0;
                shadow_code = CODE_RESET;
            end else begin
                // A result can never belong to the item accepted at this same edge.
                if (o_result_valid) begin
                    if (expected_replies.size() == 0) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: unexpected result, status %0d code %0d count %0d",
                                     $time, o_status, o_reply_code, o_active_count);
                    end else begin
                        exp_r = expected_replies.pop_front();
                        report_field("status", int'(exp_r.status), int'(o_status));
                        report_field("reply_code", int'(exp_r.code), int'(o_reply_code));
                        report_field("active_count", int'(exp_r.count), int'(o_active_count));
                    end
                end
                if (start && !busy) begin
                    seen.op           = i_op;
                    seen.key_present  = i_key_present;
                    seen.flow_key     = i_flow_key;
                    seen.max_sessions = i_max_sessions;
                    expected_replies.push_back(predict_session(seen));
                    accepted_items++;
                    item_taken = 1'b1;
                end
                if (i_cfg_valid && o_cfg_ready) begin
                    shadow_code = i_cfg_data;
                    cfg_transfers++;
                end
            end
        end
    end

    initial begin
        logic [CODE_W-1:0]     codes [RAND_PHASES];
        logic [FLOW_KEY_W-1:0] key_pool [24];
        logic [FLOW_KEY_W-1:0] key;
        logic [LIMIT_W-1:0]    lim;
        int                    pool_size;
        int                    start_pct;
        int                    writes;

        codes[0] = CODE_RESET;
        codes[1] = 10'd100;
        codes[2] = 10'd699;
        codes[3] = 10'd0;
        codes[4] = 10'h3FF;
        codes[5] = CODE_W'($urandom_range(100, 699));
        writes   = 0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: both extremes of key and limit, every status except ST_FULL.
        queue_item(OP_START, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_START, 1'b1, 32'h0000_0000, 16'd0);
        queue_item(OP_START, 1'b1, 32'h0000_0000, 16'd1);
        queue_item(OP_START, 1'b1, 32'h0000_0000, 16'd1);
        queue_item(OP_START, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_START, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_START, 1'b1, 32'hFFFF_FFFF, 16'd1);
        queue_item(OP_END,   1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_END,   1'b1, 32'h1234_5678, 16'd0);
        queue_item(OP_END,   1'b1, 32'hFFFF_FFFF, 16'd0);
        queue_item(OP_END,   1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        queue_item(OP_END,   1'b1, 32'h0000_0000, 16'd1);
        queue_item(OP_END,   1'b1, 32'h0000_0000, 16'd1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph > 0) begin
                while (!(accepted_items == queued_items && expected_replies.size() == 0))
                    @(negedge i_clk);
                repeat (SETTLE_TICKS) @(negedge i_clk);
                i_cfg_valid <= 1'b1;
                i_cfg_data  <= codes[ph];
                writes++;
                do
                    @(negedge i_clk);
                while (cfg_transfers != writes);
                i_cfg_valid <= 1'b0;
            end
            quiet = (ph == RAND_PHASES - 1);

            // A pool of 4 to 24 keys, at most a little larger than the table, can keep it near full at times.
            pool_size = $urandom_range(4, 24);
            start_pct = $urandom_range(50, 75);
            for (int k = 0; k < pool_size; k++) begin
                case ($urandom_range(0, 9))
                    0:       key_pool[k] = '0;
                    1:       key_pool[k] = '1;
                    default: key_pool[k] = $urandom;
                endcase
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 19) == 0)
                    key = $urandom;
                else
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                case ($urandom_range(0, 9))
                    0:       lim = '0;
                    1:       lim = LIMIT_W'($urandom);
                    2:       lim = '1;
                    default: lim = LIMIT_W'($urandom_range(1, 4));
                endcase
                queue_item(($urandom_range(0, 99) < start_pct) ? OP_START : OP_END,
                           $urandom_range(0, 15) != 0, key, lim);
            end
        end

        while (!(accepted_items == queued_items && expected_replies.size() == 0))
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
